// ===== src/assert_macros.svh =====
// assertion macros for the rtl, included by node_connection_slot_table
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/ncst_pkg.sv =====
// types, codes and fixed widths for the connection slot table
// no dependencies
`default_nettype none

package ncst_pkg;

  localparam int SLOT_IDX_W = 4;
  localparam int NODE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int RSLOT_W    = 3;

  localparam logic [1:0] CMD_OPEN    = 2'd0;
  localparam logic [1:0] CMD_RECEIVE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_SEND    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_NODE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

  localparam logic [NODE_W-1:0] NODE_FREE      = 8'd0;
  localparam logic [NODE_W-1:0] NODE_BROADCAST = 8'd255;

  // receive header of 18 bytes as a two's complement addend
  localparam logic [LEN_W:0]   RX_ADDEND = 12'd4078;
  localparam logic [LEN_W-1:0] LEN_MAX   = 11'd2047;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [NODE_W-1:0] node_id;
    slot_idx_t         slot_index;
    logic [LEN_W-1:0]  byte_count;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RSLOT_W-1:0]  result_slot;
    logic [NODE_W-1:0]   partner_node;
    logic [LEN_W-1:0]    length_out;
  } result_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic open_mode;
  } scan_ctl_t;

  typedef struct packed {
    logic      found;
    logic      have_free;
    slot_idx_t match_idx;
    slot_idx_t free_idx;
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== src/ncst_match.sv =====
// slot compare unit: one entry per step, tracks first match and chosen free slot
// depends on ncst_pkg
`default_nettype none

module ncst_match (
  input  wire                           clk,
  input  wire                           rst,
  input  ncst_pkg::scan_ctl_t           ctl,
  input  wire [ncst_pkg::NODE_W-1:0]    node,
  input  wire [ncst_pkg::NODE_W-1:0]    entry,
  input  ncst_pkg::slot_idx_t           index,
  output ncst_pkg::scan_stat_t          stat
);
  import ncst_pkg::*;

  scan_stat_t stat_next;
  logic       hit;
  logic       empty;

  assign hit   = (entry == node);
  assign empty = (entry == NODE_FREE);

  always_comb begin
    stat_next = stat;
    if (ctl.clear) begin
      stat_next = '0;
    end else if (ctl.step && !stat.found) begin
      if (hit) begin
        stat_next.found     = 1'b1;
        stat_next.match_idx = index;
      end else if (empty && (ctl.open_mode || !stat.have_free)) begin
        // open keeps the last free slot, receive the first
        stat_next.have_free = 1'b1;
        stat_next.free_idx  = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat <= stat_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/node_connection_slot_table.sv =====
// connection slot table: open, receive, release and send on a table of node ids
// open and receive scan one slot per cycle, then go on to the done state
// release and send skip the scan and go straight to the done state
// a new command is taken only while idle, not before the previous one is through
// done is a one-cycle strobe; the receiver cannot stall it
// synchronous reset frees every slot and returns to idle; uses ncst_pkg, ncst_match
`default_nettype none

module node_connection_slot_table #(
  parameter int unsigned SLOTS        = 8,
  parameter int unsigned HEADER_BYTES = 18
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  ncst_pkg::request_t  request,
  output logic                done,
  output ncst_pkg::result_t   result
);
  import ncst_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(SLOTS - 1);
  localparam logic [SLOT_IDX_W:0] SLOTS_LIM  = SLOTS[SLOT_IDX_W:0];
  localparam logic [LEN_W:0]      HDR_ADDEND = HEADER_BYTES[LEN_W:0];

  fsm_t                state;
  fsm_t                state_next;
  request_t            req;
  logic [IDX_W-1:0]    cnt;
  logic [NODE_W-1:0]   slot_node [SLOTS];

  logic                accept;
  scan_ctl_t           scan_ctl;
  scan_stat_t          scan_stat;
  logic [IDX_W-1:0]    rd_addr;
  logic [NODE_W-1:0]   rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [NODE_W-1:0]   wr_data;
  result_t             res_next;

  logic                is_rx;
  logic [LEN_W:0]      len_sum;
  logic [LEN_W-1:0]    len_val;
  logic                idx_ok;
  logic                err_payload;

  assign accept = start && !busy;
  assign busy   = (state != FSM_IDLE);

  assign rd_addr = (state == FSM_SCAN) ? cnt : req.slot_index[IDX_W-1:0];
  assign rd_data = slot_node[rd_addr];

  assign idx_ok = ({1'b0, req.slot_index} < SLOTS_LIM);

  // shared adder: receive subtracts the header, send adds it
  assign is_rx   = (req.command == CMD_RECEIVE);
  assign len_sum = {1'b0, req.byte_count} + (is_rx ? RX_ADDEND : HDR_ADDEND);
  assign len_val = len_sum[LEN_W] ? (is_rx ? '0 : LEN_MAX) : len_sum[LEN_W-1:0];

  // error result that still carries a partner or a length
  assign err_payload = (result.status != ST_OK) &&
                       ((|result.partner_node) || (|result.length_out));

  ncst_match u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .node  (req.node_id),
    .entry (rd_data),
    .index (SLOT_IDX_W'(cnt)),
    .stat  (scan_stat)
  );

  always_comb begin
    state_next         = state;
    scan_ctl.clear     = accept;
    scan_ctl.step      = (state == FSM_SCAN);
    scan_ctl.open_mode = (req.command == CMD_OPEN);
    wr_en              = 1'b0;
    wr_addr            = '0;
    wr_data            = req.node_id;
    res_next           = '0;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          if (request.command == CMD_OPEN || request.command == CMD_RECEIVE) begin
            state_next = FSM_SCAN;
          end else begin
            state_next = FSM_DONE;
          end
        end
      end
      FSM_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = FSM_DONE;
        end
      end
      FSM_DONE: begin
        state_next = FSM_IDLE;
        case (req.command)
          CMD_OPEN: begin
            if (req.node_id == NODE_FREE || req.node_id == NODE_BROADCAST) begin
              res_next.status = ST_BAD_NODE;
            end else if (scan_stat.found) begin
              res_next.result_slot = scan_stat.match_idx[RSLOT_W-1:0];
            end else if (scan_stat.have_free) begin
              wr_en                = 1'b1;
              wr_addr              = scan_stat.free_idx[IDX_W-1:0];
              res_next.result_slot = scan_stat.free_idx[RSLOT_W-1:0];
            end else begin
              res_next.status = ST_FULL;
            end
          end
          CMD_RECEIVE: begin
            if (scan_stat.found) begin
              res_next.result_slot = scan_stat.match_idx[RSLOT_W-1:0];
              res_next.length_out  = len_val;
            end else if (scan_stat.have_free) begin
              wr_en                = 1'b1;
              wr_addr              = scan_stat.free_idx[IDX_W-1:0];
              res_next.result_slot = scan_stat.free_idx[RSLOT_W-1:0];
              res_next.length_out  = len_val;
            end else begin
              res_next.status = ST_DROPPED;
            end
          end
          CMD_RELEASE: begin
            if (idx_ok) begin
              wr_en   = 1'b1;
              wr_addr = req.slot_index[IDX_W-1:0];
              wr_data = NODE_FREE;
            end else begin
              res_next.status = ST_BAD_SLOT;
            end
          end
          default: begin
            if (idx_ok) begin
              res_next.partner_node = rd_data;
              res_next.length_out   = len_val;
            end else begin
              res_next.status = ST_BAD_SLOT;
            end
          end
        endcase
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == FSM_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
      cnt <= '0;
    end else if (state == FSM_SCAN && cnt != LAST_IDX) begin
      cnt <= cnt + 1'b1;
    end
    if (state == FSM_DONE) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_node[i] <= NODE_FREE;
      end
    end else if (wr_en) begin
      slot_node[wr_addr] <= wr_data;
    end
  end

  `ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while a command is in flight")
  `ASSERT_CLK(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `ASSERT_CLK(a_accept_busy, accept |=> busy, "transfer did not start the sequencer")
  `ASSERT_CLK(a_err_zero, !(done && err_payload), "error result carries data")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for node_connection_slot_table: directed and random commands
// predicts each result from a shadow copy of the slot table and checks every done strobe
// depends on ncst_pkg and node_connection_slot_table
module tb;
  import ncst_pkg::*;

  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned HDR_BYTES   = 18;
  localparam int unsigned RX_HDR      = 18;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;

  logic [NODE_W-1:0] partner_tbl [NUM_SLOTS];
  result_t           pending_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on = 1'b0;

  node_connection_slot_table #(
    .SLOTS(NUM_SLOTS),
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // shadow table update and expected result for one command
  function automatic result_t table_model_step(input request_t req);
    result_t     res;
    bit          found;
    bit          have_free;
    int unsigned free_slot;
    int unsigned total;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    have_free = 1'b0;
    free_slot = 0;
    case (req.command)
      CMD_OPEN: begin
        if (req.node_id == NODE_FREE || req.node_id == NODE_BROADCAST) begin
          res.status = ST_BAD_NODE;
        end else begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found) begin
              if (partner_tbl[i] == req.node_id) begin
                res.result_slot = i[RSLOT_W-1:0];
                found = 1'b1;
              end else if (partner_tbl[i] == NODE_FREE) begin
                free_slot = i;
                have_free = 1'b1;
              end
            end
          end
          if (!found) begin
            if (have_free) begin
              partner_tbl[free_slot] = req.node_id;
              res.result_slot = free_slot[RSLOT_W-1:0];
            end else begin
              res.status = ST_FULL;
            end
          end
        end
      end
      CMD_RECEIVE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found) begin
            if (partner_tbl[i] == req.node_id) begin
              res.result_slot = i[RSLOT_W-1:0];
              found = 1'b1;
            end else if (partner_tbl[i] == NODE_FREE && !have_free) begin
              free_slot = i;
              have_free = 1'b1;
            end
          end
        end
        if (!found && have_free) begin
          partner_tbl[free_slot] = req.node_id;
          res.result_slot = free_slot[RSLOT_W-1:0];
          found = 1'b1;
        end
        if (found) begin
          res.length_out = (req.byte_count >= RX_HDR) ? LEN_W'(req.byte_count - RX_HDR) : '0;
        end else begin
          res.status = ST_DROPPED;
        end
      end
      CMD_RELEASE: begin
        if (req.slot_index >= NUM_SLOTS) begin
          res.status = ST_BAD_SLOT;
        end else begin
          partner_tbl[req.slot_index] = NODE_FREE;
        end
      end
      default: begin
        if (req.slot_index >= NUM_SLOTS) begin
          res.status = ST_BAD_SLOT;
        end else begin
          total = req.byte_count + HDR_BYTES;
          res.partner_node = partner_tbl[req.slot_index];
          res.length_out = (total > LEN_MAX) ? LEN_MAX : LEN_W'(total);
        end
      end
    endcase
    return res;
  endfunction

  // result checker: every strobe is matched against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status=%0d slot=%0d partner=%0d len=%0d",
                   result.status, result.result_slot, result.partner_node, result.length_out);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.result_slot !== want.result_slot ||
            result.partner_node !== want.partner_node ||
            result.length_out !== want.length_out) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected status=%0d slot=%0d partner=%0d len=%0d, got status=%0d slot=%0d partner=%0d len=%0d",
                     want.status, want.result_slot, want.partner_node, want.length_out,
                     result.status, result.result_slot, result.partner_node, result.length_out);
        end
      end
    end
  end

  function automatic request_t make_cmd(input logic [1:0] cmd, input logic [NODE_W-1:0] node,
                                        input slot_idx_t idx, input logic [LEN_W-1:0] cnt);
    request_t req;
    req.command = cmd;
    req.node_id = node;
    req.slot_index = idx;
    req.byte_count = cnt;
    return req;
  endfunction

  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // one command transfer, with an optional random gap in front
  task automatic send_item(input request_t req);
    if (idle_on && $urandom_range(99) < 37) hold_off($urandom_range(1, 12));
    @(negedge clk);
    start <= 1'b1;
    request <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(table_model_step(req));
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(make_cmd(CMD_SEND, 8'd0, 4'd0, 11'd0));
    send_item(make_cmd(CMD_SEND, 8'd0, 4'd7, 11'd100));
  endtask

  task automatic test_open_cases();
    send_item(make_cmd(CMD_OPEN, NODE_FREE, 4'd0, 11'd0));
    send_item(make_cmd(CMD_OPEN, NODE_BROADCAST, 4'd15, 11'd2047));
    send_item(make_cmd(CMD_OPEN, 8'd1, 4'd0, 11'd0));
    send_item(make_cmd(CMD_OPEN, 8'd1, 4'd0, 11'd0));
    send_item(make_cmd(CMD_OPEN, 8'd254, 4'd0, 11'd0));
  endtask

  task automatic test_receive_cases();
    send_item(make_cmd(CMD_RECEIVE, 8'd9, 4'd0, 11'd17));
    send_item(make_cmd(CMD_RECEIVE, NODE_FREE, 4'd0, 11'd18));
    send_item(make_cmd(CMD_RECEIVE, 8'd9, 4'd0, 11'd1518));
    send_item(make_cmd(CMD_RECEIVE, 8'd254, 4'd0, 11'd2047));
  endtask

  task automatic test_release_send_cases();
    send_item(make_cmd(CMD_SEND, 8'd0, 4'd7, 11'd2047));
    send_item(make_cmd(CMD_SEND, 8'd0, 4'd15, 11'd10));
    send_item(make_cmd(CMD_RELEASE, 8'd0, 4'd8, 11'd0));
    send_item(make_cmd(CMD_RELEASE, 8'd0, 4'd3, 11'd0));
  endtask

  task automatic test_full_table();
    for (int n = 2; n <= 6; n++) send_item(make_cmd(CMD_OPEN, 8'(n), 4'd0, 11'd0));
    send_item(make_cmd(CMD_OPEN, 8'd100, 4'd0, 11'd0));
    send_item(make_cmd(CMD_RECEIVE, 8'd77, 4'd0, 11'd64));
    send_item(make_cmd(CMD_RELEASE, 8'd0, 4'd0, 11'd0));
  endtask

  function automatic request_t random_cmd();
    request_t    req;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) req.command = CMD_OPEN;
    else if (r < 60) req.command = CMD_RECEIVE;
    else if (r < 80) req.command = CMD_RELEASE;
    else req.command = CMD_SEND;
    // small node pool so matches, fills and drops all happen often
    r = $urandom_range(99);
    if (r < 65) req.node_id = 8'($urandom_range(1, 12));
    else if (r < 72) req.node_id = ($urandom_range(1) != 0) ? NODE_BROADCAST : NODE_FREE;
    else req.node_id = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 85) req.slot_index = slot_idx_t'($urandom_range(NUM_SLOTS - 1));
    else req.slot_index = slot_idx_t'($urandom_range(15, NUM_SLOTS));
    r = $urandom_range(99);
    if (r < 10) req.byte_count = 11'($urandom_range(17));
    else if (r < 20) req.byte_count = 11'($urandom_range(2047, 2030));
    else req.byte_count = 11'($urandom_range(1518));
    return req;
  endfunction

  task automatic test_random_traffic(input int unsigned n, input bit with_idle);
    idle_on = with_idle;
    repeat (n) send_item(random_cmd());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) partner_tbl[i] = NODE_FREE;

    test_reset_state();
    test_open_cases();
    test_receive_cases();
    test_release_send_cases();
    test_full_table();
    test_random_traffic(700, 1'b1);
    wait_drained();
    test_random_traffic(300, 1'b0);
    test_random_traffic(700, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
